FILE: design/npb_pkg.sv
// ----------------------------------------------------------------------------
// npb_pkg
// Shared types, widths and helper functions of the prefix builder.
// ----------------------------------------------------------------------------
package npb_pkg;

  localparam int MAX_RECORD_BITS = 32;
  localparam int REC_W           = MAX_RECORD_BITS;
  localparam int LEN_W           = $clog2(MAX_RECORD_BITS + 1);
  localparam int POS_W           = (MAX_RECORD_BITS > 1) ? $clog2(MAX_RECORD_BITS) : 1;
  localparam int ADDR_W          = 3;
  localparam int DATA_W          = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_RECORD_BITS);

  // Register index, decoded from paddr[2].
  localparam logic REG_RECORD_LENGTH = 1'b0;

  typedef struct packed {
    logic [REC_W-1:0] pattern_bits;
    logic [LEN_W-1:0] fixed_count;
    logic             order_error;
    logic             run_last;
  } npb_result_t;

  typedef struct packed {
    logic        valid;
    npb_result_t res;
  } npb_push_t;

  typedef struct packed {
    logic [REC_W-1:0] path;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
  } npb_node_req_t;

  typedef struct packed {
    logic             emit;
    logic             last_pos;
    logic [LEN_W-1:0] depth;
    npb_result_t      res;
  } npb_node_rsp_t;

  // Mask of the n low bits; n equal to the word width gives all ones.
  function automatic logic [REC_W-1:0] low_mask(input logic [LEN_W-1:0] n);
    return ~({REC_W{1'b1}} << n);
  endfunction

  // Clamp the programmed record length into 1..MAX_RECORD_BITS.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) r = LEN_W'(1);
    else if (v > LEN_W'(MAX_RECORD_BITS)) r = LEN_W'(MAX_RECORD_BITS);
    return r;
  endfunction

endpackage

FILE: design/npb_rec_if.sv
// ----------------------------------------------------------------------------
// npb_rec_if
// Record input channel: one database record per transaction.
// ----------------------------------------------------------------------------
interface npb_rec_if import npb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REC_W-1:0] record_bits;
  logic             is_final;

  modport source (output valid, record_bits, is_final, input ready);
  modport sink   (input valid, record_bits, is_final, output ready);
endinterface

FILE: design/npb_pat_if.sv
// ----------------------------------------------------------------------------
// npb_pat_if
// Pattern output channel: one negative-database pattern per transaction.
// ----------------------------------------------------------------------------
interface npb_pat_if import npb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REC_W-1:0] pattern_bits;
  logic [LEN_W-1:0] fixed_count;
  logic             order_error;
  logic             run_last;

  modport source (output valid, pattern_bits, fixed_count, order_error, run_last,
                  input ready);
  modport sink   (input valid, pattern_bits, fixed_count, order_error, run_last,
                  output ready);
endinterface

FILE: design/negative_database_prefix_builder_unit.sv
// ----------------------------------------------------------------------------
// negative_database_prefix_builder_unit
// Streaming prefix-algorithm builder of negative-database patterns.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   rec_i     in         valid/ready          record_bits[31:0], is_final
//   pat_o     out        valid/ready          pattern_bits[31:0], fixed_count[5:0],
//                                             order_error, run_last
//   APB       in/out     psel/penable/pready  record_length at byte address 0
//
// A record is taken while the sequencer is idle; then the sequencer walks the
// previous path over the shared node unit at one trie node per cycle unless a
// stall on pat_o holds it: for a larger record the divergence walk up to bit h
// (h = highest differing bit), for a final record a flush of the whole path,
// and last the release of the last result. Reset is asynchronous and active
// low and returns the stream to an empty database with record_length 32. A stall
// on pat_o freezes the walk only when a new node result has to get past the
// pending one; rec_i is not ready until the walk for a record is done.
//
// The block keeps the previous record and one bit per trie depth that tells
// whether the node on the previous path at that depth has seen both children.
// When a larger record arrives, the nodes below the divergence depth are
// finished (each one whose bit is clear gives a pattern: the prefix followed
// by the complemented bit), and the divergence node gets its bit set while
// deeper bits are dropped. A final record flushes its whole path.
// ----------------------------------------------------------------------------
module negative_database_prefix_builder_unit import npb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  npb_rec_if.sink           rec_i,
  npb_pat_if.source         pat_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [LEN_W-1:0] record_length_q, record_length_d;
  logic [LEN_W-1:0] len;
  logic             cfg_write;
  logic             slot_free;
  npb_push_t        push;

  // Registers are word aligned; paddr[2] picks the register, low bits are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    record_length_d = record_length_q;
    if (cfg_write && paddr[2] == REG_RECORD_LENGTH) begin
      record_length_d = pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RECORD_LENGTH) begin
      prdata = DATA_W'(record_length_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_length_q <= LEN_RESET;
    end else begin
      record_length_q <= record_length_d;
    end
  end

  // Out-of-range lengths are clamped to 1..MAX_RECORD_BITS before use.
  assign len = eff_len(record_length_q);

  npb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .len_i       (len),
    .in_valid_i  (rec_i.valid),
    .in_bits_i   (rec_i.record_bits),
    .in_final_i  (rec_i.is_final),
    .in_ready_o  (rec_i.ready),
    .slot_free_i (slot_free),
    .push_o      (push)
  );

  npb_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .slot_free_o (slot_free),
    .pat_o       (pat_o)
  );

endmodule

FILE: design/npb_node_unit.sv
// ----------------------------------------------------------------------------
// npb_node_unit
// Shared trie-node unit: builds the pattern for one node of a record path.
// ----------------------------------------------------------------------------
module npb_node_unit import npb_pkg::*; (
  input  npb_node_req_t    req_i,
  input  logic [REC_W-1:0] bcs_i,
  output npb_node_rsp_t    rsp_o
);

  logic [LEN_W-1:0] pos_ext;
  logic [LEN_W-1:0] depth;
  logic [REC_W-1:0] keep;
  logic [REC_W-1:0] bit_sel;

  // Bit position pos holds the record bit at depth len-1-pos.
  always_comb begin
    pos_ext = LEN_W'(req_i.pos);
    depth   = req_i.len - pos_ext - LEN_W'(1);
    keep    = low_mask(req_i.len) & ({{(REC_W-1){1'b1}}, 1'b0} << req_i.pos);
    bit_sel = REC_W'(1) << req_i.pos;

    rsp_o.emit                 = ~bcs_i[depth[POS_W-1:0]];
    rsp_o.last_pos             = (depth == '0);
    rsp_o.depth                = depth;
    rsp_o.res.pattern_bits     = (req_i.path & keep) | (~req_i.path & bit_sel);
    rsp_o.res.fixed_count      = req_i.len - pos_ext;
    rsp_o.res.order_error      = 1'b0;
    rsp_o.res.run_last         = 1'b0;
  end

endmodule

FILE: design/npb_out_stage.sv
// ----------------------------------------------------------------------------
// npb_out_stage
// Output register between the sequencer and the pattern channel.
// ----------------------------------------------------------------------------
module npb_out_stage import npb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  npb_push_t   push_i,
  output logic        slot_free_o,
  npb_pat_if.source   pat_o
);

  logic        valid_q, valid_d;
  npb_result_t res_q;

  assign slot_free_o = ~valid_q | pat_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (push_i.valid) begin
      valid_d = 1'b1;
    end else if (pat_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      res_q <= push_i.res;
    end
  end

  assign pat_o.valid        = valid_q;
  assign pat_o.pattern_bits = res_q.pattern_bits;
  assign pat_o.fixed_count  = res_q.fixed_count;
  assign pat_o.order_error  = res_q.order_error;
  assign pat_o.run_last     = res_q.run_last;

endmodule

FILE: design/npb_seq.sv
// ----------------------------------------------------------------------------
// npb_seq
// Sequencer: stream state, path walk over the shared node unit, and the
// one-deep pending result that lets the last result of a record be marked.
// ----------------------------------------------------------------------------
module npb_seq import npb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LEN_W-1:0] len_i,
  input  logic             in_valid_i,
  input  logic [REC_W-1:0] in_bits_i,
  input  logic             in_final_i,
  output logic             in_ready_o,
  input  logic             slot_free_i,
  output npb_push_t        push_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [REC_W-1:0] prev_q, prev_d;
  logic [REC_W-1:0] bcs_q, bcs_d;
  logic             have_q, have_d;
  logic [REC_W-1:0] walk_q, walk_d;
  logic [REC_W-1:0] xs_q, xs_d;
  logic [REC_W-1:0] nxt_q, nxt_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             fin_q, fin_d;
  logic             pend_v_q, pend_v_d;
  npb_result_t      pend_q, pend_d;

  logic [REC_W-1:0] mask;
  logic [REC_W-1:0] rec;
  logic [REC_W-1:0] prv;
  logic             advance;
  logic             flush_done;
  npb_node_req_t    node_req;
  npb_node_rsp_t    node_rsp;

  assign node_req = '{path: walk_q, pos: pos_q, len: len_i};

  npb_node_unit u_node (
    .req_i (node_req),
    .bcs_i (bcs_q),
    .rsp_o (node_rsp)
  );

  // A new node result must wait while the pending one cannot move on.
  assign advance    = ~(node_rsp.emit & pend_v_q & ~slot_free_i);
  assign flush_done = (state_q == ST_FLUSH) & advance & node_rsp.last_pos;

  always_comb begin
    state_d    = state_q;
    prev_d     = prev_q;
    bcs_d      = bcs_q;
    have_d     = have_q;
    walk_d     = walk_q;
    xs_d       = xs_q;
    nxt_d      = nxt_q;
    pos_d      = pos_q;
    fin_d      = fin_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    push_o     = '0;
    in_ready_o = 1'b0;
    mask       = low_mask(len_i);
    rec        = in_bits_i & mask;
    prv        = prev_q & mask;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pos_d = '0;
          fin_d = in_final_i;
          if (!have_q) begin
            prev_d  = rec;
            bcs_d   = '0;
            have_d  = 1'b1;
            walk_d  = rec;
            state_d = in_final_i ? ST_FLUSH : ST_FIN;
          end else begin
            prev_d = prv;
            walk_d = prv;
            if (rec < prv) begin
              pend_v_d = 1'b1;
              pend_d   = '{pattern_bits: '0, fixed_count: '0,
                           order_error: 1'b1, run_last: 1'b0};
              state_d  = in_final_i ? ST_FLUSH : ST_FIN;
            end else if (rec > prv) begin
              xs_d    = prv ^ rec;
              nxt_d   = rec;
              state_d = ST_DIV;
            end else begin
              state_d = in_final_i ? ST_FLUSH : ST_FIN;
            end
          end
        end
      end

      ST_DIV: begin
        if (xs_q[REC_W-1:1] == '0) begin
          // pos_q now sits on the first differing bit: that node saw both children.
          bcs_d   = (bcs_q | (REC_W'(1) << node_rsp.depth[POS_W-1:0]))
                  & ~({{(REC_W-1){1'b1}}, 1'b0} << node_rsp.depth[POS_W-1:0]);
          prev_d  = nxt_q;
          walk_d  = nxt_q;
          pos_d   = '0;
          state_d = fin_q ? ST_FLUSH : ST_FIN;
        end else if (advance) begin
          pos_d = pos_q + POS_W'(1);
          xs_d  = xs_q >> 1;
          if (node_rsp.emit) begin
            push_o   = '{valid: pend_v_q, res: pend_q};
            pend_v_d = 1'b1;
            pend_d   = node_rsp.res;
          end
        end
      end

      ST_FLUSH: begin
        if (advance) begin
          pos_d = pos_q + POS_W'(1);
          if (node_rsp.emit) begin
            push_o   = '{valid: pend_v_q, res: pend_q};
            pend_v_d = 1'b1;
            pend_d   = node_rsp.res;
          end
          if (node_rsp.last_pos) begin
            prev_d  = '0;
            bcs_d   = '0;
            have_d  = 1'b0;
            state_d = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (slot_free_i) begin
          push_o.valid        = 1'b1;
          push_o.res          = pend_q;
          push_o.res.run_last = 1'b1;
          pend_v_d            = 1'b0;
          state_d             = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      prev_q   <= '0;
      bcs_q    <= '0;
      have_q   <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      prev_q   <= prev_d;
      bcs_q    <= bcs_d;
      have_q   <= have_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q <= walk_d;
    xs_q   <= xs_d;
    nxt_q  <= nxt_d;
    pos_q  <= pos_d;
    fin_q  <= fin_d;
    pend_q <= pend_d;
  end

  // A result is only handed over when the output register can take it.
  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> slot_free_i)
    else $error("result pushed into a full output register");

  // The divergence walk always has a differing bit left to stop on.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (xs_q != '0))
    else $error("divergence walk lost its differing bit");

  // A completed flush starts a new database.
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_done |=> (!have_q && bcs_q == '0 && prev_q == '0))
    else $error("stream state not cleared after flush");

  // A status result carries no pattern; a node result carries a nonzero count.
  a_pend_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (pend_q.order_error ? (pend_q.fixed_count == '0 &&
                                        pend_q.pattern_bits == '0)
                                     : (pend_q.fixed_count != '0)))
    else $error("pending result has an inconsistent shape");

endmodule
